// ===== rtl/pms_pkg.sv =====
// ----------------------------------------------------------------------------
// pms_pkg: shared definitions for the particle motion step
// Fixed-point format, saturation helpers and configuration register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pms_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [2:0] {
		CFG_TIME_STEP    = 3'd0,
		CFG_ANIM_PHASE   = 3'd1,
		CFG_CENTER_X     = 3'd2,
		CFG_CENTER_Y     = 3'd3,
		CFG_ATTRACT_GAIN = 3'd4,
		CFG_DAMPING      = 3'd5,
		CFG_TURB_AMP     = 3'd6,
		CFG_LIFE_START   = 3'd7
	} cfg_idx_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(64'(a) + 64'(b));
	endfunction

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(64'(a) - 64'(b));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pms_sin.sv =====
// ----------------------------------------------------------------------------
// pms_sin: pipelined fixed-point sine
// Range reduction to the nearest multiple of two pi, then an odd 7th-order
// polynomial in Q28. Seven register stages, advancing when en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_sin (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [31:0]                  x,
	output logic signed [pms_pkg::FRAC_BITS+3:0]     s
);

	localparam int F  = pms_pkg::FRAC_BITS;
	localparam int QW = 32 - F;
	localparam int YW = F + 4;
	localparam logic [63:0]        INV2PI_Q32 = 64'd683565276;
	localparam logic signed [63:0] TWOPI_Q32  = 64'sd26986075409;
	localparam logic signed [35:0] SC7 = -36'sd53260;
	localparam logic signed [35:0] SC5 = 36'sd2236961;
	localparam logic signed [35:0] SC3 = -36'sd44739244;
	localparam logic signed [35:0] Q28 = 36'sd268435456;

	function automatic logic signed [35:0] m28(input logic signed [35:0] a,
			input logic signed [35:0] b);
		logic signed [71:0] p;
		p = 72'(a) * 72'(b) + (72'sd1 <<< 27);
		return 36'(p >>> 28);
	endfunction

	logic [31:0]        mag;
	logic [63:0]        qprod;
	logic [QW-1:0]      qq;
	logic signed [63:0] td;
	logic signed [63:0] yfull;
	logic signed [35:0] y28;
	logic signed [35:0] sq;

	logic signed [QW:0]    q_s1;
	logic signed [31:0]    x_s1;
	logic signed [YW-1:0]  y_s2;
	logic signed [35:0]    y28_s3, y28_s4, y28_s5, y28_s6;
	logic signed [35:0]    y2_s3, y2_s4, y2_s5;
	logic signed [35:0]    p_s4, p_s5, p_s6;

	always_comb begin
		mag   = x[31] ? (~x + 32'd1) : x;
		qprod = 64'(mag) * INV2PI_Q32 + (64'd1 << (31 + F));
		qq    = QW'(qprod >> (32 + F));
		td    = (64'(q_s1) * TWOPI_Q32 + (64'sd1 <<< (31 - F))) >>> (32 - F);
		yfull = 64'(x_s1) - td;
		y28   = 36'(y_s2) <<< (28 - F);
		sq    = m28(y28_s6, p_s6);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1   <= x[31] ? -$signed({1'b0, qq}) : $signed({1'b0, qq});
			x_s1   <= x;
			y_s2   <= YW'(yfull);
			y28_s3 <= y28;
			y2_s3  <= m28(y28, y28);
			p_s4   <= m28(SC7, y2_s3) + SC5;
			y2_s4  <= y2_s3;
			y28_s4 <= y28_s3;
			p_s5   <= m28(y2_s4, p_s4) + SC3;
			y2_s5  <= y2_s4;
			y28_s5 <= y28_s4;
			p_s6   <= m28(y2_s5, p_s5) + Q28;
			y28_s6 <= y28_s5;
			s      <= YW'((sq + (36'sd1 <<< (27 - F))) >>> (28 - F));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pms_div.sv =====
// ----------------------------------------------------------------------------
// pms_div: pipelined restoring divider for alpha
// Gives floor(num * 2^F / den) for 0 <= num < den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_div (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic [30:0]                     num,
	input  wire logic [30:0]                     den,
	output logic [pms_pkg::FRAC_BITS-1:0]        q
);

	localparam int F = pms_pkg::FRAC_BITS;

	logic [30:0]  r_s  [F];
	logic [F-1:0] q_s  [F];
	logic [30:0]  r_nx [F];
	logic [F-1:0] q_nx [F];
	logic [31:0]  r2   [F];
	logic         ge   [F];

	always_comb begin
		for (int j = 0; j < F; j++) begin
			r2[j]   = (j == 0) ? {num, 1'b0} : {r_s[j-1], 1'b0};
			ge[j]   = r2[j] >= {1'b0, den};
			r_nx[j] = ge[j] ? 31'(r2[j] - {1'b0, den}) : r2[j][30:0];
			q_nx[j] = (j == 0) ? F'(ge[j]) : {q_s[j-1][F-2:0], ge[j]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < F; j++) begin
				r_s[j] <= r_nx[j];
				q_s[j] <= q_nx[j];
			end
		end
	end

	assign q = q_s[F-1];

endmodule

`default_nettype wire

// ===== rtl/particle_motion_step.sv =====
// ----------------------------------------------------------------------------
// particle_motion_step: one particle update per item
// Attraction, sine turbulence, damped integration, rotation, life and respawn,
// with alpha and pulsing scale, in a 21-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         tvalid/tready      particle state, tlast
//  m_*       out        tvalid/tready      updated particle, scale, alpha, tlast
//  cfg_*     in         cfg_we             register index and data
//
// One item enters per cycle unless m_tready stalls the pipeline; each result is
// offered once its item has passed through every stage.
// The alpha divider produces one quotient bit per stage.
// Reset clears the valid bits and loads the register defaults.
// A stall on m_tready freezes every stage, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_motion_step (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// pos_x, pos_y, vel_x, vel_y, rotation, life
	input  wire logic [191:0]  s_tdata,
	input  wire logic          s_tlast,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// pos_x, pos_y, vel_x, vel_y, rotation, scale, alpha, life, zero pad
	output logic [231:0]       m_tdata,
	output logic               m_tlast,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);

	localparam int F = pms_pkg::FRAC_BITS;
	localparam int NS = 21;
	localparam logic signed [31:0] TURB_FREQ_X = 32'sd655;
	localparam logic signed [31:0] TURB_FREQ_Y = 32'sd655;
	localparam logic signed [31:0] ROT_GAIN = 32'sd65536;
	localparam logic signed [31:0] PULSE = 32'((2 * pms_pkg::ONE + 5) / 10);

	function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + (64'sd1 <<< (F - 1));
		return pms_pkg::sat32(p >>> F);
	endfunction

	logic [16:0]        dt_q, damp_q;
	logic [30:0]        life0_q;
	logic signed [31:0] phase_q, cx_q, cy_q, gain_q, amp_q;
	logic signed [31:0] dt32, damp32, life032;

	logic [NS:1] vld_s;
	logic        en;

	logic signed [31:0] xi, yi, vxi, vyi, roti, lifei;

	logic signed [31:0] ptx_s1, pty_s1, dx_s1, dy_s1, lm_s1, lm_s2;
	logic signed [31:0] argx_s2, argy_s2;
	logic signed [31:0] x_s [1:14];
	logic signed [31:0] y_s [1:14];
	logic signed [31:0] rot_s [1:16];
	logic               last_s [1:20];
	logic signed [31:0] fdx_s [1:12];
	logic signed [31:0] fdy_s [1:12];
	logic signed [31:0] ax_s [2:10];
	logic signed [31:0] ay_s [2:10];
	logic               dead_s [2:20];
	logic signed [31:0] ln_s [3:20];
	logic               az_s [4:19];
	logic               ao_s [4:19];
	logic signed [31:0] a3_s4, sarg_s5;
	logic signed [31:0] tx_s10, ty_s10, sax_s11, say_s11, fvx_s12, fvy_s12;
	logic signed [31:0] fm_s13;
	logic signed [31:0] vx_s [13:20];
	logic signed [31:0] vy_s [13:20];
	logic signed [31:0] fpx_s14, fpy_s14, rsum_s14;
	logic [F:0]         sc_s [14:20];
	logic signed [31:0] px_s [15:20];
	logic signed [31:0] py_s [15:20];
	logic signed [31:0] rg_s15, fr_s16;
	logic signed [31:0] ro_s [17:20];
	logic [F:0]         al_s20;
	logic signed [31:0] sc_sum;

	logic signed [31:0] px_s21, py_s21, vx_s21, vy_s21, ro_s21, ln_s21;
	logic [F:0]         sc_s21, al_s21;
	logic               last_s21;

	logic signed [F+3:0] stx, sty, ssc;
	logic [F-1:0]        dq;

	assign dt32    = $signed(32'(dt_q));
	assign damp32  = $signed(32'(damp_q));
	assign life032 = $signed(32'(life0_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q    <= 17'd1092;
			phase_q <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			gain_q  <= '0;
			damp_q  <= 17'd65536;
			amp_q   <= '0;
			life0_q <= 31'd65536;
		end else if (cfg_we) begin
			unique case (pms_pkg::cfg_idx_t'(cfg_index))
				pms_pkg::CFG_TIME_STEP:    dt_q    <= cfg_data[16:0];
				pms_pkg::CFG_ANIM_PHASE:   phase_q <= cfg_data;
				pms_pkg::CFG_CENTER_X:     cx_q    <= cfg_data;
				pms_pkg::CFG_CENTER_Y:     cy_q    <= cfg_data;
				pms_pkg::CFG_ATTRACT_GAIN: gain_q  <= cfg_data;
				pms_pkg::CFG_DAMPING:      damp_q  <= cfg_data[16:0];
				pms_pkg::CFG_TURB_AMP:     amp_q   <= cfg_data;
				pms_pkg::CFG_LIFE_START:   life0_q <= cfg_data[30:0];
			endcase
		end
	end

	assign en       = !vld_s[NS] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], s_tvalid};
		end
	end

	assign xi    = s_tdata[31:0];
	assign yi    = s_tdata[63:32];
	assign vxi   = s_tdata[95:64];
	assign vyi   = s_tdata[127:96];
	assign roti  = s_tdata[159:128];
	assign lifei = s_tdata[191:160];

	pms_sin u_sin_tx (.clk(clk), .en(en), .x(argx_s2), .s(stx));
	pms_sin u_sin_ty (.clk(clk), .en(en), .x(argy_s2), .s(sty));
	pms_sin u_sin_sc (.clk(clk), .en(en), .x(sarg_s5), .s(ssc));
	pms_div u_div (.clk(clk), .en(en), .num(ln_s[3][30:0]), .den(life0_q), .q(dq));

	assign sc_sum = pms_pkg::sat_add(pms_pkg::ONE, fm_s13);

	always_ff @(posedge clk) begin
		if (en) begin
			ptx_s1    <= fmul(xi, TURB_FREQ_X);
			pty_s1    <= fmul(yi, TURB_FREQ_Y);
			dx_s1     <= pms_pkg::sat_sub(cx_q, xi);
			dy_s1     <= pms_pkg::sat_sub(cy_q, yi);
			fdx_s[1]  <= fmul(vxi, damp32);
			fdy_s[1]  <= fmul(vyi, damp32);
			lm_s1     <= pms_pkg::sat_sub(lifei, dt32);
			x_s[1]    <= xi;
			y_s[1]    <= yi;
			rot_s[1]  <= roti;
			last_s[1] <= s_tlast;

			argx_s2   <= pms_pkg::sat_add(pty_s1, phase_q);
			argy_s2   <= pms_pkg::sat_sub(ptx_s1, phase_q);
			ax_s[2]   <= fmul(dx_s1, gain_q);
			ay_s[2]   <= fmul(dy_s1, gain_q);
			dead_s[2] <= (64'(lm_s1) * 64'sd10000000) < 64'(pms_pkg::ONE);
			lm_s2     <= lm_s1;

			ln_s[3]   <= dead_s[2] ? pms_pkg::sat_add(lm_s2, life032) : lm_s2;

			a3_s4     <= pms_pkg::sat32(64'(ln_s[3]) * 64'sd3);
			az_s[4]   <= ln_s[3] <= 32'sd0;
			ao_s[4]   <= (life0_q == 31'd0) || (ln_s[3] >= life032);

			sarg_s5   <= pms_pkg::sat_add(a3_s4, phase_q);

			tx_s10    <= fmul(amp_q, 32'(stx));
			ty_s10    <= fmul(amp_q, 32'(sty));
			sax_s11   <= pms_pkg::sat_add(ax_s[10], tx_s10);
			say_s11   <= pms_pkg::sat_add(ay_s[10], ty_s10);
			fvx_s12   <= fmul(sax_s11, dt32);
			fvy_s12   <= fmul(say_s11, dt32);
			vx_s[13]  <= pms_pkg::sat_add(fdx_s[12], fvx_s12);
			vy_s[13]  <= pms_pkg::sat_add(fdy_s[12], fvy_s12);
			fm_s13    <= fmul(PULSE, 32'(ssc));

			fpx_s14   <= fmul(vx_s[13], dt32);
			fpy_s14   <= fmul(vy_s[13], dt32);
			rsum_s14  <= pms_pkg::sat_add(vx_s[13], vy_s[13]);
			sc_s[14]  <= sc_sum[31] ? '0 : sc_sum[F:0];

			px_s[15]  <= pms_pkg::sat_add(fpx_s14, x_s[14]);
			py_s[15]  <= pms_pkg::sat_add(fpy_s14, y_s[14]);
			rg_s15    <= fmul(rsum_s14, ROT_GAIN);
			fr_s16    <= fmul(rg_s15, dt32);
			ro_s[17]  <= pms_pkg::sat_add(fr_s16, rot_s[16]);

			al_s20    <= az_s[19] ? '0 : (ao_s[19] ? pms_pkg::ONE[F:0] : {1'b0, dq});

			px_s21    <= dead_s[20] ? cx_q : px_s[20];
			py_s21    <= dead_s[20] ? cy_q : py_s[20];
			vx_s21    <= dead_s[20] ? '0 : vx_s[20];
			vy_s21    <= dead_s[20] ? '0 : vy_s[20];
			ro_s21    <= ro_s[20];
			sc_s21    <= sc_s[20];
			al_s21    <= al_s20;
			ln_s21    <= ln_s[20];
			last_s21  <= last_s[20];

			for (int i = 2; i <= 14; i++) begin
				x_s[i] <= x_s[i-1];
				y_s[i] <= y_s[i-1];
			end
			for (int i = 2; i <= 16; i++) rot_s[i] <= rot_s[i-1];
			for (int i = 2; i <= 20; i++) last_s[i] <= last_s[i-1];
			for (int i = 2; i <= 12; i++) begin
				fdx_s[i] <= fdx_s[i-1];
				fdy_s[i] <= fdy_s[i-1];
			end
			for (int i = 3; i <= 10; i++) begin
				ax_s[i] <= ax_s[i-1];
				ay_s[i] <= ay_s[i-1];
			end
			for (int i = 3; i <= 20; i++) dead_s[i] <= dead_s[i-1];
			for (int i = 4; i <= 20; i++) ln_s[i] <= ln_s[i-1];
			for (int i = 5; i <= 19; i++) begin
				az_s[i] <= az_s[i-1];
				ao_s[i] <= ao_s[i-1];
			end
			for (int i = 14; i <= 20; i++) begin
				vx_s[i] <= vx_s[i-1];
				vy_s[i] <= vy_s[i-1];
			end
			for (int i = 15; i <= 20; i++) sc_s[i] <= sc_s[i-1];
			for (int i = 16; i <= 20; i++) begin
				px_s[i] <= px_s[i-1];
				py_s[i] <= py_s[i-1];
			end
			for (int i = 18; i <= 20; i++) ro_s[i] <= ro_s[i-1];
		end
	end

	assign m_tdata = {6'd0, ln_s21, al_s21, sc_s21, ro_s21, vy_s21, vx_s21, py_s21, px_s21};
	assign m_tlast = last_s21;

endmodule

`default_nettype wire

// ===== rtl/pms_chk.sv =====
// ----------------------------------------------------------------------------
// pms_chk: port-level checks for particle_motion_step
// Output handshake stability, backpressure coupling and result ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module pms_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          s_tready,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [231:0]  m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output space");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[193:177] <= 17'd65536) && (m_tdata[176:160] <= 17'd98304))
		else $error("alpha or scale out of range");

endmodule

bind particle_motion_step pms_chk u_pms_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

`default_nettype wire
